FILE: src/circle_outline_rasterizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circle outline rasterizer
// Expect a clock named clk and an active-low reset named rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OUTLINE_RASTERIZER_UNIT_ASSERT_SVH
`define CIRCLE_OUTLINE_RASTERIZER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define COR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define COR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/cor_pkg.sv
// ----------------------------------------------------------------------------
// cor_pkg
// Shared widths, limits and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cor_pkg;

  localparam int MAX_RADIUS  = 63;
  localparam int COORD_WIDTH = 12;
  localparam int RAD_W       = 6;
  localparam int OFS_W       = 7;
  localparam int DEC_W       = 9;
  localparam int OUT_W       = 14;
  localparam int MAX_STEPS   = 46;
  localparam int CNT_W       = 6;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 8 * OUT_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;   // capture a new circle
    logic emit;   // write one step to the output register and advance
  } cmd_t;

  typedef struct packed {
    logic last;      // current step is the final one of the circle
    logic out_free;  // output register can take a step this cycle
  } sts_t;

endpackage

FILE: src/cor_ctrl.sv
// ----------------------------------------------------------------------------
// cor_ctrl
// Controller: idle/run sequencing of the octant walk.
// ----------------------------------------------------------------------------
module cor_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cor_pkg::sts_t sts,
  output cor_pkg::cmd_t cmd
);
  import cor_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.out_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_RUN: begin
        cmd.emit = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/cor_dp.sv
// ----------------------------------------------------------------------------
// cor_dp
// Datapath: circle registers, offsets, decision value and output register.
// ----------------------------------------------------------------------------
module cor_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cor_pkg::IN_DATA_W-1:0]     in_tdata,
  input  cor_pkg::cmd_t                     cmd,
  output cor_pkg::sts_t                     sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cor_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast
);
  import cor_pkg::*;

  localparam int DW = DEC_W + 2;  // working width of the decision update

  logic [COORD_WIDTH-1:0]  cx_r, cy_r;
  logic [RAD_W-1:0]        rad_r;
  logic [OFS_W-1:0]        ox_r;
  logic signed [OFS_W:0]   oy_r;   // drops to -1 after radius zero
  logic signed [DEC_W-1:0] d_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_last_r;
  logic                    out_valid_r;

  logic [COORD_WIDTH-1:0]  in_cx, in_cy;
  logic [RAD_W-1:0]        in_rad, rad_sat;

  logic signed [DW-1:0]    d_w, ox_w, oy_w, r_w, d_n;
  logic [OFS_W-1:0]        ox_nxt;
  logic signed [OFS_W:0]   oy_nxt;
  logic                    more;

  logic signed [OUT_W-1:0] cx14, cy14, ox14, oy14;

  assign in_cx   = in_tdata[COORD_WIDTH-1:0];
  assign in_cy   = in_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign in_rad  = in_tdata[2*COORD_WIDTH+RAD_W-1:2*COORD_WIDTH];
  assign rad_sat = (in_rad > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : in_rad;

  // decision rule: step in x, step in y, or diagonal
  always_comb begin
    d_w    = DW'(d_r);
    ox_w   = DW'(ox_r);
    oy_w   = DW'(oy_r);
    r_w    = DW'(rad_r);
    d_n    = d_w;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    priority if (d_w >= (ox_w <<< 1)) begin
      d_n    = d_w - (ox_w <<< 1) - DW'(1);
      ox_nxt = ox_r + OFS_W'(1);
    end else if (d_w < ((r_w - oy_w) <<< 1)) begin
      d_n    = d_w + (oy_w <<< 1) - DW'(1);
      oy_nxt = oy_r - (OFS_W+1)'(1);
    end else begin
      d_n    = d_w + ((oy_w - ox_w - DW'(1)) <<< 1);
      ox_nxt = ox_r + OFS_W'(1);
      oy_nxt = oy_r - (OFS_W+1)'(1);
    end
  end

  assign more = (oy_nxt >= $signed({1'b0, ox_nxt})) &&
                (cnt_r != CNT_W'(MAX_STEPS - 1));

  assign sts.last     = !more;
  assign sts.out_free = !out_valid_r || out_tready;

  assign cx14 = OUT_W'(cx_r);
  assign cy14 = OUT_W'(cy_r);
  assign ox14 = OUT_W'(ox_r);
  assign oy14 = OUT_W'(oy_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r  <= in_cx;
      cy_r  <= in_cy;
      rad_r <= rad_sat;
      ox_r  <= '0;
      oy_r  <= $signed({2'b00, rad_sat});
      d_r   <= $signed(DEC_W'(rad_sat)) - DEC_W'(1);
      cnt_r <= '0;
    end else if (cmd.emit) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      d_r   <= d_n[DEC_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.emit) begin
      out_data_r <= {cy14 - ox14, cy14 + ox14, cy14 - oy14, cy14 + oy14,
                     cx14 - oy14, cx14 + oy14, cx14 - ox14, cx14 + ox14};
      out_last_r <= !more;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: src/circle_outline_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// circle_outline_rasterizer_unit
// Andres circle walk over one octant, eight mirrored coordinates per step.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per circle (center x, center y, radius).
//   out_* : one transaction per octant step; out_tlast marks the final step.
//   A circle of radius r gives about r/sqrt(2)+1 steps, 46 at most; radius 0
//   gives one step at the center.
// Timing:
//   The walk emits one step per cycle, while the output is not stalled,
//   through a single output register; the input transaction loads the
//   circle registers and the controller goes to run, which writes the first
//   step to the output register. The next circle is taken as soon as the
//   final step is in the output register, even while that step still waits.
// Stalls:
//   With out_tready low while a step waits, the walk freezes and the output holds.
// Reset:
//   rst_n low (synchronous) returns to idle and drops out_tvalid.
// ----------------------------------------------------------------------------
module circle_outline_rasterizer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [11:0] center_x, [23:12] center_y, [29:24] circle_radius, [31:30] zero
  input  logic [cor_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [13:0] x_plus_ox, [27:14] x_minus_ox, [41:28] x_plus_oy,
  // [55:42] x_minus_oy, [69:56] y_plus_oy, [83:70] y_minus_oy,
  // [97:84] y_plus_ox, [111:98] y_minus_ox
  output logic [cor_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import cor_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cor_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cor_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`include "circle_outline_rasterizer_unit_assert.svh"

  // a new circle always produces at least one step before the next is taken
  `COR_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // the final step hands control back to idle
  `COR_ASSERT_NEXT(a_idle_after_last, cmd.emit && sts.last, in_tready)
  // loading and stepping never overlap
  `COR_ASSERT_NOW(a_load_emit_excl, cmd.load, !cmd.emit)
  // a step is only written when the output register is free
  `COR_ASSERT_NOW(a_emit_no_overwrite, out_tvalid && !out_tready, !cmd.emit)

endmodule
